### sv/cdr_pkg.sv
`default_nettype none

package cdr_pkg;

    localparam int unsigned CHORD_W  = 8;
    localparam int unsigned BANK_W   = 8;
    localparam int unsigned TIME_W   = 32;
    localparam int unsigned MS_W     = 16;
    localparam int unsigned CFG_IDX_W = 8;
    localparam int unsigned CFG_DAT_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_CLICK = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_DELAY = 8'd1;

    localparam logic [MS_W-1:0] DOUBLE_CLICK_RST = 16'd300;
    localparam logic [MS_W-1:0] REPEAT_DELAY_RST = 16'd500;

    localparam logic [1:0] CLICK_NONE   = 2'd0;
    localparam logic [1:0] CLICK_SINGLE = 2'd1;
    localparam logic [1:0] CLICK_DOUBLE = 2'd2;

    typedef struct packed {
        logic [CHORD_W-1:0] chord;
        logic [BANK_W-1:0]  bank;
        logic               bank_valid;
        logic [TIME_W-1:0]  time_ms;
    } report_t;

    typedef struct packed {
        logic               emit;
        logic [BANK_W-1:0]  emit_bank;
        logic [CHORD_W-1:0] emit_chord;
        logic               repeating;
    } result_t;

    typedef struct packed {
        logic [MS_W-1:0] double_click_ms;
        logic [MS_W-1:0] repeat_delay_ms;
    } cfg_t;

endpackage

`default_nettype wire

### sv/cdr_in_if.sv
`default_nettype none

interface cdr_in_if;
    logic                          valid;
    logic                          ready;
    logic [cdr_pkg::CHORD_W-1:0]   chord;
    logic [cdr_pkg::BANK_W-1:0]    bank;
    logic                          bank_valid;
    logic [cdr_pkg::TIME_W-1:0]    time_ms;

    modport source (output valid, output chord, output bank, output bank_valid,
                    output time_ms, input ready);
    modport sink   (input valid, input chord, input bank, input bank_valid,
                    input time_ms, output ready);
endinterface

`default_nettype wire

### sv/cdr_out_if.sv
`default_nettype none

interface cdr_out_if;
    logic                          valid;
    logic                          ready;
    logic                          emit;
    logic [cdr_pkg::BANK_W-1:0]    emit_bank;
    logic [cdr_pkg::CHORD_W-1:0]   emit_chord;
    logic                          repeating;

    modport source (output valid, output emit, output emit_bank, output emit_chord,
                    output repeating, input ready);
    modport sink   (input valid, input emit, input emit_bank, input emit_chord,
                    input repeating, output ready);
endinterface

`default_nettype wire

### sv/cdr_cfg_if.sv
`default_nettype none

interface cdr_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [cdr_pkg::CFG_IDX_W-1:0]   index;
    logic [cdr_pkg::CFG_DAT_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### sv/chord_keyboard_repeat_decoder.sv
// Chord keyboard repeat decoder.
//
// in_req  : one request per keyboard report (chord, bank, bank_valid, time_ms).
// out_res : exactly one result per report (emit, emit_bank, emit_chord,
//           repeating), in report order.
// cfg     : register writes, index 0 = double_click_ms, 1 = repeat_delay_ms;
//           always ready, other indexes are dropped. Write only while idle.
//
// A report is captured in an input register, decoded combinationally against
// the chord state, and the result lands in an output register. One report
// per cycle is sustained while the receiver is ready; the state update of
// one report is visible to the next.
//
// Reset clears the chord state and both valid flags and loads the
// configuration defaults (300 ms and 500 ms).
// When the receiver stalls, the output register holds its result and the
// input register holds the next report; in_req.ready drops once both are
// full and returns in the cycle out_res.ready comes back.
`default_nettype none

module chord_keyboard_repeat_decoder (
    input  wire logic  clk,
    input  wire logic  rst_n,
    cdr_in_if.sink     in_req,
    cdr_out_if.source  out_res,
    cdr_cfg_if.sink    cfg
);

    cdr_pkg::report_t rpt_reg;
    logic             rpt_valid_reg, rpt_valid_next;
    cdr_pkg::result_t res_reg;
    logic             res_valid_reg, res_valid_next;
    cdr_pkg::result_t res_comb;
    cdr_pkg::cfg_t    cfg_cur;
    logic             advance;
    logic             take;

    assign advance = rpt_valid_reg && (!res_valid_reg || out_res.ready);
    assign in_req.ready = !rpt_valid_reg || advance;
    assign take = in_req.valid && in_req.ready;

    cdr_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .cfg_out (cfg_cur)
    );

    cdr_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .rpt     (rpt_reg),
        .cfg     (cfg_cur),
        .res     (res_comb)
    );

    always_comb
    begin
        rpt_valid_next = rpt_valid_reg;
        if (take)
        begin
            rpt_valid_next = 1'b1;
        end
        else if (advance)
        begin
            rpt_valid_next = 1'b0;
        end

        res_valid_next = res_valid_reg;
        if (advance)
        begin
            res_valid_next = 1'b1;
        end
        else if (out_res.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rpt_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            rpt_valid_reg <= rpt_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            rpt_reg.chord      <= in_req.chord;
            rpt_reg.bank       <= in_req.bank;
            rpt_reg.bank_valid <= in_req.bank_valid;
            rpt_reg.time_ms    <= in_req.time_ms;
        end
        if (advance)
        begin
            res_reg <= res_comb;
        end
    end

    assign out_res.valid      = res_valid_reg;
    assign out_res.emit       = res_reg.emit;
    assign out_res.emit_bank  = res_reg.emit_bank;
    assign out_res.emit_chord = res_reg.emit_chord;
    assign out_res.repeating  = res_reg.repeating;

endmodule

`default_nettype wire

### sv/cdr_cfg_regs.sv
`default_nettype none

module cdr_cfg_regs (
    input  wire logic    clk,
    input  wire logic    rst_n,
    cdr_cfg_if.sink      cfg,
    output cdr_pkg::cfg_t cfg_out
);

    cdr_pkg::cfg_t cfg_reg;
    cdr_pkg::cfg_t cfg_next;

    assign cfg.ready = 1'b1;
    assign cfg_out   = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                cdr_pkg::REG_DOUBLE_CLICK: cfg_next.double_click_ms = cfg.data;
                cdr_pkg::REG_REPEAT_DELAY: cfg_next.repeat_delay_ms = cfg.data;
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.double_click_ms <= cdr_pkg::DOUBLE_CLICK_RST;
            cfg_reg.repeat_delay_ms <= cdr_pkg::REPEAT_DELAY_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

### sv/cdr_core.sv
`default_nettype none

module cdr_core (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              advance,
    input  wire cdr_pkg::report_t  rpt,
    input  wire cdr_pkg::cfg_t     cfg,
    output cdr_pkg::result_t       res
);

    logic [cdr_pkg::CHORD_W-1:0] prev_chord_reg,    prev_chord_next;
    logic                        sent_mark_reg,     sent_mark_next;
    logic [1:0]                  click_count_reg,   click_count_next;
    logic [cdr_pkg::CHORD_W-1:0] pressed_chord_reg, pressed_chord_next;
    logic [cdr_pkg::TIME_W-1:0]  first_time_reg,    first_time_next;
    logic [cdr_pkg::TIME_W-1:0]  second_time_reg,   second_time_next;

    logic [cdr_pkg::TIME_W-1:0]  since_first;
    logic [cdr_pkg::TIME_W-1:0]  since_second;
    logic                        fast;
    logic                        held_long;

    // wrapping differences read as signed; config values are never negative
    assign since_first  = rpt.time_ms - first_time_reg;
    assign since_second = rpt.time_ms - second_time_reg;
    assign fast      = $signed(since_first)
                       < $signed({{(cdr_pkg::TIME_W-cdr_pkg::MS_W){1'b0}}, cfg.double_click_ms});
    assign held_long = $signed(since_second)
                       > $signed({{(cdr_pkg::TIME_W-cdr_pkg::MS_W){1'b0}}, cfg.repeat_delay_ms});

    always_comb
    begin
        prev_chord_next    = prev_chord_reg;
        sent_mark_next     = sent_mark_reg;
        click_count_next   = click_count_reg;
        pressed_chord_next = pressed_chord_reg;
        first_time_next    = first_time_reg;
        second_time_next   = second_time_reg;
        res                = '0;

        if (rpt.bank_valid)
        begin
            if (rpt.chord < prev_chord_reg)
            begin
                // first release after building up: send the held chord
                if (!sent_mark_reg)
                begin
                    sent_mark_next     = 1'b1;
                    res.emit           = 1'b1;
                    res.emit_bank      = rpt.bank;
                    res.emit_chord     = prev_chord_reg;
                    pressed_chord_next = prev_chord_reg;
                    if (pressed_chord_reg != prev_chord_reg)
                    begin
                        click_count_next = cdr_pkg::CLICK_SINGLE;
                        first_time_next  = rpt.time_ms;
                    end
                end
                prev_chord_next = rpt.chord;
            end
            else if (rpt.chord != pressed_chord_reg)
            begin
                sent_mark_next  = 1'b0;
                prev_chord_next = rpt.chord;
            end
            else if (rpt.chord > prev_chord_reg)
            begin
                // re-press of the sent chord
                sent_mark_next   = 1'b0;
                second_time_next = rpt.time_ms;
                prev_chord_next  = rpt.chord;
                click_count_next = fast ? cdr_pkg::CLICK_DOUBLE : cdr_pkg::CLICK_SINGLE;
                if (!fast)
                begin
                    first_time_next = rpt.time_ms;
                end
                res.repeating = 1'b1;
            end
            else if (click_count_reg == cdr_pkg::CLICK_DOUBLE)
            begin
                first_time_next = rpt.time_ms;
                if (held_long)
                begin
                    res.emit       = 1'b1;
                    res.emit_bank  = rpt.bank;
                    res.emit_chord = rpt.chord;
                end
                res.repeating = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_chord_reg    <= '0;
            sent_mark_reg     <= 1'b0;
            click_count_reg   <= cdr_pkg::CLICK_NONE;
            pressed_chord_reg <= '0;
            first_time_reg    <= '0;
            second_time_reg   <= '0;
        end
        else if (advance)
        begin
            prev_chord_reg    <= prev_chord_next;
            sent_mark_reg     <= sent_mark_next;
            click_count_reg   <= click_count_next;
            pressed_chord_reg <= pressed_chord_next;
            first_time_reg    <= first_time_next;
            second_time_reg   <= second_time_next;
        end
    end

endmodule

`default_nettype wire

### bench/tb_chord_keyboard_repeat_decoder.sv
`timescale 1ns / 100ps

module tb_chord_keyboard_repeat_decoder;

    localparam int CHORD_W = cdr_pkg::CHORD_W;
    localparam int BANK_W = cdr_pkg::BANK_W;
    localparam int TIME_W = cdr_pkg::TIME_W;
    localparam int CFG_IDX_W = cdr_pkg::CFG_IDX_W;
    localparam int CFG_DAT_W = cdr_pkg::CFG_DAT_W;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 10;
    localparam int IDLE_PCT = 32;
    localparam int ITEMS_PER_PHASE = 125;
    localparam int PHASES = 6;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 8'hff;

    // Chord state tracker and store of expected decode results.
    class chord_scoreboard;
        cdr_pkg::cfg_t      regs;
        logic [CHORD_W-1:0] prev_chord;
        logic [CHORD_W-1:0] pressed_chord;
        logic               sent_mark;
        logic [1:0]         clicks;
        logic [TIME_W-1:0]  first_ms;
        logic [TIME_W-1:0]  second_ms;
        cdr_pkg::result_t   expected_q[$];
        int                 errors;

        function new();
            regs.double_click_ms = cdr_pkg::DOUBLE_CLICK_RST;
            regs.repeat_delay_ms = cdr_pkg::REPEAT_DELAY_RST;
            prev_chord = '0;
            pressed_chord = '0;
            sent_mark = 1'b0;
            clicks = cdr_pkg::CLICK_NONE;
            first_ms = '0;
            second_ms = '0;
            errors = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] value);
            if (idx == cdr_pkg::REG_DOUBLE_CLICK)
                regs.double_click_ms = value;
            else if (idx == cdr_pkg::REG_REPEAT_DELAY)
                regs.repeat_delay_ms = value;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_report(cdr_pkg::report_t r);
            cdr_pkg::result_t res;
            int               gap;
            res = '0;
            if (r.bank_valid)
            begin
                // first release after building up
                if (r.chord < prev_chord && !sent_mark)
                begin
                    sent_mark = 1'b1;
                    res.emit = 1'b1;
                    res.emit_bank = r.bank;
                    res.emit_chord = prev_chord;
                    if (pressed_chord != prev_chord)
                    begin
                        clicks = cdr_pkg::CLICK_SINGLE;
                        first_ms = r.time_ms;
                    end
                    pressed_chord = prev_chord;
                end
                if (r.chord < prev_chord)
                begin
                    prev_chord = r.chord;
                end
                else if (r.chord != pressed_chord)
                begin
                    sent_mark = 1'b0;
                    prev_chord = r.chord;
                end
                else if (r.chord > prev_chord)
                begin
                    // re-press of the emitted chord
                    sent_mark = 1'b0;
                    second_ms = r.time_ms;
                    gap = $signed(r.time_ms - first_ms);
                    clicks = (gap < int'(regs.double_click_ms)) ? cdr_pkg::CLICK_DOUBLE
                                                                : cdr_pkg::CLICK_SINGLE;
                    prev_chord = r.chord;
                    if (clicks == cdr_pkg::CLICK_SINGLE)
                        first_ms = r.time_ms;
                    res.repeating = 1'b1;
                end
                else if (clicks == cdr_pkg::CLICK_DOUBLE)
                begin
                    // held after a double press
                    first_ms = r.time_ms;
                    gap = $signed(r.time_ms - second_ms);
                    if (gap > int'(regs.repeat_delay_ms))
                    begin
                        res.emit = 1'b1;
                        res.emit_bank = r.bank;
                        res.emit_chord = r.chord;
                    end
                    res.repeating = 1'b1;
                end
            end
            expected_q.push_back(res);
        endfunction

        function void check_result(cdr_pkg::result_t got);
            cdr_pkg::result_t want;
            if (expected_q.size() == 0)
            begin
                $error("result arrived with no pending report");
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got.emit !== want.emit)
            begin
                $error("emit: expected %0d, actual %0d", want.emit, got.emit);
                errors++;
            end
            if (got.emit_bank !== want.emit_bank)
            begin
                $error("emit_bank: expected %0d, actual %0d", want.emit_bank, got.emit_bank);
                errors++;
            end
            if (got.emit_chord !== want.emit_chord)
            begin
                $error("emit_chord: expected 0x%02h, actual 0x%02h",
                       want.emit_chord, got.emit_chord);
                errors++;
            end
            if (got.repeating !== want.repeating)
            begin
                $error("repeating: expected %0d, actual %0d", want.repeating, got.repeating);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic steady = 1'b0;
    logic [TIME_W-1:0] now_ms;
    int sent_items = 0;
    int cycles = 0;
    cdr_pkg::report_t seen_report;
    cdr_pkg::result_t seen_result;
    chord_scoreboard sb = new();

    cdr_in_if  in_if();
    cdr_out_if out_if();
    cdr_cfg_if cfg_if();

    chord_keyboard_repeat_decoder dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_req  (in_if),
        .out_res (out_if),
        .cfg     (cfg_if)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && in_if.valid && in_if.ready)
        begin
            seen_report.chord = in_if.chord;
            seen_report.bank = in_if.bank;
            seen_report.bank_valid = in_if.bank_valid;
            seen_report.time_ms = in_if.time_ms;
            sb.note_report(seen_report);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_if.valid && out_if.ready)
        begin
            seen_result.emit = out_if.emit;
            seen_result.emit_bank = out_if.emit_bank;
            seen_result.emit_chord = out_if.emit_chord;
            seen_result.repeating = out_if.repeating;
            sb.check_result(seen_result);
        end
    end

    initial
    begin
        out_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            out_if.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    task automatic send_report(input logic [CHORD_W-1:0] chord, input logic [BANK_W-1:0] bank,
                               input logic bank_valid, input logic [TIME_W-1:0] stamp);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            in_if.valid <= 1'b0;
            @(posedge clk);
        end
        in_if.valid <= 1'b1;
        in_if.chord <= chord;
        in_if.bank <= bank;
        in_if.bank_valid <= bank_valid;
        in_if.time_ms <= stamp;
        do @(posedge clk); while (!in_if.ready);
        sent_items++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] value);
        // drain the pipeline before touching a register
        in_if.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data <= value;
        do @(posedge clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        sb.write_reg(idx, value);
    endtask

    task automatic advance_clock_ms();
        int pick;
        pick = $urandom_range(99);
        if (pick < 65)
            now_ms = now_ms + $urandom_range(0, 400);
        else if (pick < 85)
            now_ms = now_ms + $urandom_range(0, 70000);
        else if (pick < 93)
            now_ms = now_ms - $urandom_range(1, 300);
        else
            now_ms = $urandom();
    endtask

    task automatic key_report(input logic [CHORD_W-1:0] held, input logic [BANK_W-1:0] bank);
        logic [BANK_W-1:0] b;
        b = ($urandom_range(99) < 10) ? BANK_W'($urandom()) : bank;
        advance_clock_ms();
        send_report(held, b, $urandom_range(99) >= 4, now_ms);
    endtask

    // Build a chord key by key, hold, release, and maybe press it again.
    task automatic play_gesture();
        logic [CHORD_W-1:0] target;
        logic [CHORD_W-1:0] held;
        logic [BANK_W-1:0]  bank;
        int start;
        int presses;
        int keep;
        target = CHORD_W'($urandom_range(1, 255));
        bank = BANK_W'($urandom());
        held = '0;
        presses = $urandom_range(1, 3);
        for (int p = 0; p < presses; p++)
        begin
            start = $urandom_range(0, 7);
            for (int i = 0; i < 8; i++)
            begin
                int k;
                k = (start + i) % 8;
                if (target[k] && !held[k])
                begin
                    held[k] = 1'b1;
                    key_report(held, bank);
                end
            end
            repeat ($urandom_range(0, 4)) key_report(held, bank);
            // release fully on the last press, sometimes partly before a re-press
            keep = (p < presses - 1 && $urandom_range(99) < 30) ? 1 : 0;
            start = $urandom_range(0, 7);
            for (int i = 0; i < 8; i++)
            begin
                int k;
                k = (start + i) % 8;
                if (held[k] && !(keep != 0 && held != target))
                begin
                    held[k] = 1'b0;
                    key_report(held, bank);
                end
            end
        end
    endtask

    initial
    begin
        logic [CFG_DAT_W-1:0] dc_set [PHASES];
        logic [CFG_DAT_W-1:0] rd_set [PHASES];
        int base;
        dc_set = '{16'hffff, 16'h0000, 16'd1, 16'hffff, 16'h0000, 16'd300};
        rd_set = '{16'hffff, 16'h0000, 16'hffff, 16'h0000, 16'h0000, 16'd500};
        rst_n = 1'b0;
        in_if.valid = 1'b0;
        in_if.chord = '0;
        in_if.bank = '0;
        in_if.bank_valid = 1'b0;
        in_if.time_ms = '0;
        cfg_if.valid = 1'b0;
        cfg_if.index = '0;
        cfg_if.data = '0;
        now_ms = $urandom();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: single press, double press, repeat, wrap, backward time
        send_report(8'hff, 8'hff, 1'b0, 32'hffffffff);
        send_report(8'h01, 8'h00, 1'b1, 32'd1000);
        send_report(8'h03, 8'h00, 1'b1, 32'd1010);
        send_report(8'h01, 8'hff, 1'b1, 32'd1020);
        send_report(8'h00, 8'h5a, 1'b1, 32'd1030);
        send_report(8'h01, 8'h5a, 1'b1, 32'd1050);
        send_report(8'h03, 8'h5a, 1'b1, 32'd1100);
        send_report(8'h03, 8'h5a, 1'b1, 32'd1300);
        send_report(8'h03, 8'ha5, 1'b1, 32'd1700);
        send_report(8'h00, 8'h00, 1'b1, 32'd1710);
        send_report(8'h03, 8'h33, 1'b1, 32'd5000);
        send_report(8'h00, 8'h33, 1'b1, 32'd5010);
        send_report(8'h0f, 8'h44, 1'b1, 32'hffffff00);
        send_report(8'hff, 8'h44, 1'b1, 32'hffffff10);
        send_report(8'h00, 8'h80, 1'b1, 32'hffffff80);
        send_report(8'hff, 8'h01, 1'b1, 32'h00000010);
        send_report(8'hff, 8'h7f, 1'b1, 32'h00000400);
        send_report(8'h00, 8'hfe, 1'b1, 32'h00000410);
        send_report(8'hff, 8'h12, 1'b1, 32'h00000100);
        send_report(8'hff, 8'h12, 1'b1, 32'h00000200);
        send_report(8'hff, 8'h12, 1'b1, 32'h80000200);
        send_report(8'h7f, 8'h12, 1'b0, 32'h80000250);
        send_report(8'h00, 8'hff, 1'b1, 32'h80000300);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph == 4)
            begin
                dc_set[ph] = CFG_DAT_W'($urandom_range(0, 1000));
                rd_set[ph] = CFG_DAT_W'($urandom_range(0, 2000));
            end
            if (ph == 0)
                write_reg(REG_UNMAPPED, CFG_DAT_W'($urandom()));
            write_reg(cdr_pkg::REG_DOUBLE_CLICK, dc_set[ph]);
            write_reg(cdr_pkg::REG_REPEAT_DELAY, rd_set[ph]);
            steady <= (ph == 2);
            base = sent_items;
            while (sent_items - base < ITEMS_PER_PHASE)
            begin
                if ($urandom_range(99) < 12)
                begin
                    advance_clock_ms();
                    send_report(CHORD_W'($urandom()), BANK_W'($urandom()),
                                1'($urandom_range(1)), now_ms);
                end
                else
                begin
                    play_gesture();
                end
            end
        end

        in_if.valid <= 1'b0;
        steady <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
